FILE: rtl/core/fexp_pkg.sv
// package: single-precision arithmetic helpers and constants for the exp pipeline
`default_nettype none
package fexp_pkg;

   // number of register stages, output register included
   localparam int NUM_STAGES = 12;

   typedef logic [NUM_STAGES:1] stage_en_type;

   localparam logic [31:0] ONE_BITS     = 32'h3F80_0000;
   localparam logic [31:0] INV_LN2_BITS = 32'h3FB8_AA3B;
   localparam logic [31:0] LN2_BITS     = 32'h3F31_7218;
   localparam logic [31:0] C2_BITS      = 32'h3F00_0000;
   localparam logic [31:0] C3_BITS      = 32'h3E2A_AAAB;
   localparam logic [31:0] C4_BITS      = 32'h3D2A_AAAB;
   localparam logic [31:0] C5_BITS      = 32'h3C08_8889;
   localparam logic [31:0] C6_BITS      = 32'h3AB6_0B61;
   localparam logic [31:0] HI_BITS      = 32'h42B0_0000;  // 88.0
   localparam logic [30:0] LO_MAG_BITS  = 31'h42AE_0000;  // magnitude of -87.0
   localparam logic [31:0] QNAN_BITS    = 32'h7FC0_0000;
   localparam logic [31:0] PINF_BITS    = 32'h7F80_0000;
   localparam logic [7:0]  EXP_BIAS     = 8'd127;

   // single-precision multiply, round to nearest even, subnormals kept
   function automatic logic [31:0] fp_mul(input logic [31:0] a, input logic [31:0] b);
      logic               sgn;
      logic [23:0]        ma;
      logic [23:0]        mb;
      logic [9:0]         ea;
      logic [9:0]         eb;
      logic [47:0]        prod;
      logic [47:0]        norm;
      logic [5:0]         lz;
      logic               found;
      logic signed [11:0] ee;
      logic signed [11:0] sh;
      logic [11:0]        rs;
      logic               lost;
      logic               rnd;
      logic [7:0]         ef;
      logic [30:0]        body;
      sgn   = a[31] ^ b[31];
      ma    = {|a[30:23], a[22:0]};
      mb    = {|b[30:23], b[22:0]};
      ea    = (a[30:23] == 8'd0) ? 10'd1 : {2'b00, a[30:23]};
      eb    = (b[30:23] == 8'd0) ? 10'd1 : {2'b00, b[30:23]};
      prod  = ma * mb;
      lz    = 6'd0;
      found = 1'b0;
      for (int i = 47; i >= 0; i--) begin
         if (!found) begin
            if (prod[i]) found = 1'b1;
            else lz = lz + 6'd1;
         end
      end
      ee   = $signed({2'b00, ea}) + $signed({2'b00, eb}) - 12'sd126 - $signed({6'd0, lz});
      sh   = (ee >= 12'sd1) ? $signed({6'd0, lz}) : $signed({6'd0, lz}) + ee - 12'sd1;
      lost = 1'b0;
      if (sh >= 12'sd0) begin
         norm = prod << sh[5:0];
      end else begin
         rs = 12'(-sh);
         if (rs >= 12'd48) begin
            norm = 48'd0;
            lost = |prod;
         end else begin
            norm = prod >> rs[5:0];
            lost = |(prod & ((48'd1 << rs[5:0]) - 48'd1));
         end
      end
      rnd  = norm[23] & ((|norm[22:0]) | lost | norm[24]);
      ef   = (ee >= 12'sd1) ? ee[7:0] : 8'd0;
      body = {ef, norm[46:24]} + {30'd0, rnd};
      if (prod == 48'd0) return {sgn, 31'd0};
      else if (ee >= 12'sd255) return {sgn, PINF_BITS[30:0]};
      else return {sgn, body};
   endfunction

   // single-precision add, round to nearest even, subnormals kept
   function automatic logic [31:0] fp_add(input logic [31:0] a, input logic [31:0] b);
      logic [31:0] big;
      logic [31:0] sml;
      logic [23:0] ma;
      logic [23:0] mb;
      logic [9:0]  ea;
      logic [9:0]  eb;
      logic [9:0]  d;
      logic [26:0] bx;
      logic [26:0] sx0;
      logic [26:0] sx;
      logic [27:0] sum;
      logic [26:0] nrm;
      logic [9:0]  e;
      logic [4:0]  lz;
      logic [4:0]  shl;
      logic        found;
      logic        rnd;
      logic [7:0]  ef;
      logic [30:0] body;
      big = (b[30:0] > a[30:0]) ? b : a;
      sml = (b[30:0] > a[30:0]) ? a : b;
      ma  = {|big[30:23], big[22:0]};
      mb  = {|sml[30:23], sml[22:0]};
      ea  = (big[30:23] == 8'd0) ? 10'd1 : {2'b00, big[30:23]};
      eb  = (sml[30:23] == 8'd0) ? 10'd1 : {2'b00, sml[30:23]};
      d   = ea - eb;
      bx  = {ma, 3'b000};
      sx0 = {mb, 3'b000};
      if (d >= 10'd27) begin
         sx = {26'd0, |mb};
      end else begin
         sx    = sx0 >> d[4:0];
         sx[0] = sx[0] | (|(sx0 & ((27'd1 << d[4:0]) - 27'd1)));
      end
      if (a[31] ^ b[31]) sum = {1'b0, bx} - {1'b0, sx};
      else sum = {1'b0, bx} + {1'b0, sx};
      e     = ea;
      lz    = 5'd0;
      found = 1'b0;
      for (int i = 26; i >= 0; i--) begin
         if (!found) begin
            if (sum[i]) found = 1'b1;
            else lz = lz + 5'd1;
         end
      end
      if (sum[27]) begin
         nrm = {sum[27:2], sum[1] | sum[0]};
         e   = e + 10'd1;
      end else begin
         shl = ((e - 10'd1) < {5'd0, lz}) ? 5'(e - 10'd1) : lz;
         nrm = sum[26:0] << shl;
         e   = e - {5'd0, shl};
      end
      ef   = nrm[26] ? e[7:0] : 8'd0;
      rnd  = nrm[2] & (nrm[1] | nrm[0] | nrm[3]);
      body = {ef, nrm[25:3]} + {30'd0, rnd};
      if (sum == 28'd0) return {a[31] & b[31], 31'd0};
      else if (e >= 10'd255) return {big[31], PINF_BITS[30:0]};
      else return {big[31], body};
   endfunction

   // nearest integer, halves away from zero; magnitude saturates at 256
   function automatic logic signed [9:0] fp_round_away(input logic [31:0] t);
      logic [7:0]  e;
      logic [23:0] q;
      logic [8:0]  mag;
      logic [9:0]  ext;
      logic [8:0]  up;
      e = t[30:23];
      q = 24'd0;
      if (e < 8'd126) begin
         mag = 9'd0;
      end else if (e > 8'd134) begin
         mag = 9'd256;
      end else begin
         q   = {1'b1, t[22:0]} >> (8'd149 - e);
         up  = q[8:0] + 9'd1;
         mag = (q[8:0] == 9'h1FF) ? 9'd256 : {1'b0, up[8:1]};
      end
      ext = {1'b0, mag};
      return t[31] ? $signed(10'(-ext)) : $signed(ext);
   endfunction

   // exact conversion of a small integer to single precision
   function automatic logic [31:0] fp_from_int(input logic signed [9:0] n);
      logic [9:0]  mag;
      logic [4:0]  p;
      logic [23:0] tmp;
      mag = n[9] ? 10'(-n) : n;
      p   = 5'd0;
      for (int i = 0; i < 10; i++) begin
         if (mag[i]) p = 5'(i);
      end
      tmp = {14'd0, mag} << (5'd23 - p);
      if (mag == 10'd0) return 32'd0;
      else return {n[9], EXP_BIAS + {3'd0, p}, tmp[22:0]};
   endfunction

endpackage
`default_nettype wire

FILE: rtl/core/fexp_reduce.sv
// range reduction stages: t = x/ln2, n = round(t), r = x - n*ln2
`default_nettype none
module fexp_reduce
   import fexp_pkg::*;
(
   input  wire logic              clock,
   input  wire stage_en_type      stage_en,
   input  wire logic [31:0]       x_bits,
   output logic [31:0]            r_bits,
   output logic signed [9:0]      n_out
);

   logic [31:0]        x1_ff, x2_ff, x3_ff;
   logic [31:0]        t1_ff, t1_in;
   logic [31:0]        nf2_ff, nf2_in;
   logic signed [9:0]  n2_ff, n2_in, n3_ff, n4_ff;
   logic [31:0]        m3_ff, m3_in;
   logic [31:0]        r4_ff, r4_in;

   always_comb begin
      t1_in  = fp_mul(x_bits, INV_LN2_BITS);
      n2_in  = fp_round_away(t1_ff);
      nf2_in = fp_from_int(n2_in);
      m3_in  = fp_mul(nf2_ff, LN2_BITS);
      r4_in  = fp_add(x3_ff, {~m3_ff[31], m3_ff[30:0]});
   end

   always_ff @(posedge clock) begin
      if (stage_en[1]) begin
         x1_ff <= x_bits;
         t1_ff <= t1_in;
      end
      if (stage_en[2]) begin
         x2_ff  <= x1_ff;
         n2_ff  <= n2_in;
         nf2_ff <= nf2_in;
      end
      if (stage_en[3]) begin
         x3_ff <= x2_ff;
         n3_ff <= n2_ff;
         m3_ff <= m3_in;
      end
      if (stage_en[4]) begin
         r4_ff <= r4_in;
         n4_ff <= n3_ff;
      end
   end

   assign r_bits = r4_ff;
   assign n_out  = n4_ff;

endmodule
`default_nettype wire

FILE: rtl/core/fexp_poly.sv
// polynomial stages: powers of r, scaled terms and left-to-right sum
`default_nettype none
module fexp_poly
   import fexp_pkg::*;
(
   input  wire logic              clock,
   input  wire stage_en_type      stage_en,
   input  wire logic [31:0]       r_bits,
   input  wire logic signed [9:0] n_in,
   output logic [31:0]            p_bits,
   output logic signed [9:0]      n_out
);

   logic signed [9:0] n5_ff, n6_ff, n7_ff, n8_ff, n9_ff, n10_ff, n11_ff;
   logic [31:0] r5_ff, r6_ff;
   logic [31:0] sq5_ff, sq5_in, sq6_ff;
   logic [31:0] p0_5_ff, p0_5_in, p0_6_ff;
   logic [31:0] cu6_ff, cu6_in, qu6_ff, qu6_in, a2_6_ff, a2_6_in;
   logic [31:0] p1_7_ff, p1_7_in, r5p_7_ff, r5p_7_in, r6p_7_ff, r6p_7_in;
   logic [31:0] a3_7_ff, a3_7_in, a4_7_ff, a4_7_in;
   logic [31:0] p2_8_ff, p2_8_in, a4_8_ff, a5_8_ff, a5_8_in, a6_8_ff, a6_8_in;
   logic [31:0] p3_9_ff, p3_9_in, a5_9_ff, a6_9_ff;
   logic [31:0] p4_10_ff, p4_10_in, a6_10_ff;
   logic [31:0] p5_11_ff, p5_11_in;

   always_comb begin
      sq5_in   = fp_mul(r_bits, r_bits);
      p0_5_in  = fp_add(ONE_BITS, r_bits);
      cu6_in   = fp_mul(sq5_ff, r5_ff);
      qu6_in   = fp_mul(sq5_ff, sq5_ff);
      a2_6_in  = fp_mul(C2_BITS, sq5_ff);
      p1_7_in  = fp_add(p0_6_ff, a2_6_ff);
      r5p_7_in = fp_mul(qu6_ff, r6_ff);
      r6p_7_in = fp_mul(qu6_ff, sq6_ff);
      a3_7_in  = fp_mul(C3_BITS, cu6_ff);
      a4_7_in  = fp_mul(C4_BITS, qu6_ff);
      p2_8_in  = fp_add(p1_7_ff, a3_7_ff);
      a5_8_in  = fp_mul(C5_BITS, r5p_7_ff);
      a6_8_in  = fp_mul(C6_BITS, r6p_7_ff);
      p3_9_in  = fp_add(p2_8_ff, a4_8_ff);
      p4_10_in = fp_add(p3_9_ff, a5_9_ff);
      p5_11_in = fp_add(p4_10_ff, a6_10_ff);
   end

   always_ff @(posedge clock) begin
      if (stage_en[5]) begin
         r5_ff   <= r_bits;
         sq5_ff  <= sq5_in;
         p0_5_ff <= p0_5_in;
         n5_ff   <= n_in;
      end
      if (stage_en[6]) begin
         r6_ff   <= r5_ff;
         sq6_ff  <= sq5_ff;
         p0_6_ff <= p0_5_ff;
         cu6_ff  <= cu6_in;
         qu6_ff  <= qu6_in;
         a2_6_ff <= a2_6_in;
         n6_ff   <= n5_ff;
      end
      if (stage_en[7]) begin
         p1_7_ff  <= p1_7_in;
         r5p_7_ff <= r5p_7_in;
         r6p_7_ff <= r6p_7_in;
         a3_7_ff  <= a3_7_in;
         a4_7_ff  <= a4_7_in;
         n7_ff    <= n6_ff;
      end
      if (stage_en[8]) begin
         p2_8_ff <= p2_8_in;
         a4_8_ff <= a4_7_ff;
         a5_8_ff <= a5_8_in;
         a6_8_ff <= a6_8_in;
         n8_ff   <= n7_ff;
      end
      if (stage_en[9]) begin
         p3_9_ff <= p3_9_in;
         a5_9_ff <= a5_8_ff;
         a6_9_ff <= a6_8_ff;
         n9_ff   <= n8_ff;
      end
      if (stage_en[10]) begin
         p4_10_ff <= p4_10_in;
         a6_10_ff <= a6_9_ff;
         n10_ff   <= n9_ff;
      end
      if (stage_en[11]) begin
         p5_11_ff <= p5_11_in;
         n11_ff   <= n10_ff;
      end
   end

   assign p_bits = p5_11_ff;
   assign n_out  = n11_ff;

endmodule
`default_nettype wire

FILE: rtl/core/float32_exp_approx_unit.sv
// top level: pipelined single-precision exponential with valid/stall channels
//
// req channel: one beat carries req_x_bits (ieee single) and req_last_in;
// a beat is taken at a rising edge with req_valid high and req_stall low.
// rsp channel: one beat per request, in order, with rsp_y_bits = exp(x)
// and rsp_last_out copied from the request's last flag.
// the result comes from 12 register stages, about one single-precision
// operation deep each; the last one is the output register, fed by the
// final scale multiply, and rsp_valid rises when the beat is loaded there.
// throughput: one beat per cycle while req_stall is low.
// nan gives quiet nan, x above 88 gives +inf, x below -87 gives +0.
// reset (synchronous, active high) empties the pipeline; no results are
// pending after it and the block takes a beat in the very next cycle.
// when the receiver stalls, the output register holds its beat and the
// stages behind it keep filling any empty slots, so req_stall only rises
// once every stage is occupied. no beat is lost or repeated.
`default_nettype none
module float32_exp_approx_unit
   import fexp_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [31:0] req_x_bits,
   input  wire logic        req_last_in,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [31:0]      rsp_y_bits,
   output logic             rsp_last_out
);

   // special-case class, decided at the first stage
   typedef enum logic [1:0] {
      SPC_NONE,
      SPC_NAN,
      SPC_INF,
      SPC_ZERO
   } special_type;

   logic [NUM_STAGES:1] valid_ff, valid_in;
   stage_en_type        stage_en;

   // sideband travelling beside the datapath
   logic        last_ff [1:NUM_STAGES];
   special_type spc_ff  [1:NUM_STAGES-1];
   special_type spc_in;

   logic [31:0]       r_bits, p_bits;
   logic signed [9:0] n_red, n_poly;
   logic [7:0]        scale_field;
   logic [31:0]       y_ff, y_in;

   // a stage may load when it is empty or its content moves on
   always_comb begin
      stage_en[NUM_STAGES] = !valid_ff[NUM_STAGES] || !rsp_stall;
      for (int k = NUM_STAGES - 1; k >= 1; k--) begin
         stage_en[k] = !valid_ff[k] || stage_en[k+1];
      end
   end

   always_comb begin
      valid_in[1] = stage_en[1] ? req_valid : valid_ff[1];
      for (int k = 2; k <= NUM_STAGES; k++) begin
         valid_in[k] = stage_en[k] ? valid_ff[k-1] : valid_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // classify the input: nan first, then the two clamp ranges
   always_comb begin
      if (req_x_bits[30:0] > PINF_BITS[30:0]) spc_in = SPC_NAN;
      else if (!req_x_bits[31] && (req_x_bits[30:0] > HI_BITS[30:0])) spc_in = SPC_INF;
      else if (req_x_bits[31] && (req_x_bits[30:0] > LO_MAG_BITS)) spc_in = SPC_ZERO;
      else spc_in = SPC_NONE;
   end

   always_ff @(posedge clock) begin
      if (stage_en[1]) begin
         last_ff[1] <= req_last_in;
         spc_ff[1]  <= spc_in;
      end
      for (int k = 2; k < NUM_STAGES; k++) begin
         if (stage_en[k]) begin
            last_ff[k] <= last_ff[k-1];
            spc_ff[k]  <= spc_ff[k-1];
         end
      end
      if (stage_en[NUM_STAGES]) begin
         last_ff[NUM_STAGES] <= last_ff[NUM_STAGES-1];
         y_ff                <= y_in;
      end
   end

   fexp_reduce u_reduce (
      .clock    (clock),
      .stage_en (stage_en),
      .x_bits   (req_x_bits),
      .r_bits   (r_bits),
      .n_out    (n_red)
   );

   fexp_poly u_poly (
      .clock    (clock),
      .stage_en (stage_en),
      .r_bits   (r_bits),
      .n_in     (n_red),
      .p_bits   (p_bits),
      .n_out    (n_poly)
   );

   // scale 2^n as a float with exponent field 127 + n, then the final product
   assign scale_field = EXP_BIAS + n_poly[7:0];

   always_comb begin
      case (spc_ff[NUM_STAGES-1])
         SPC_NAN:  y_in = QNAN_BITS;
         SPC_INF:  y_in = PINF_BITS;
         SPC_ZERO: y_in = 32'd0;
         default:  y_in = fp_mul(p_bits, {1'b0, scale_field, 23'd0});
      endcase
   end

   assign req_stall    = !stage_en[1];
   assign rsp_valid    = valid_ff[NUM_STAGES];
   assign rsp_y_bits   = y_ff;
   assign rsp_last_out = last_ff[NUM_STAGES];

endmodule
`default_nettype wire

FILE: rtl/core/fexp_checker.sv
// checker: port-level properties of the exp unit, bound to the top level
`default_nettype none
module fexp_checker
   import fexp_pkg::*;
(
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_stall,
   input wire logic        rsp_valid,
   input wire logic        rsp_stall,
   input wire logic [31:0] rsp_y_bits,
   input wire logic        rsp_last_out
);

   // a stalled result beat holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_y_bits) && $stable(rsp_last_out))
      else $error("stalled result beat changed");

   // the pipeline only pushes back when the receiver does
   assert property (@(posedge clock) disable iff (reset)
      !rsp_stall |-> !req_stall)
      else $error("request stalled while result side is free");

   // any nan result is the canonical quiet nan
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_y_bits[30:0] > PINF_BITS[30:0]) |-> rsp_y_bits == QNAN_BITS)
      else $error("non-canonical nan on result");

   // exp never yields a negative value
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !rsp_y_bits[31])
      else $error("negative result");

endmodule

bind float32_exp_approx_unit fexp_checker u_fexp_checker (.*);
`default_nettype wire

FILE: verif/float32_exp_approx_unit_tb.sv
// testbench for the pipelined single-precision exponential unit
`timescale 1ns / 1ps
`default_nettype none

module float32_exp_approx_unit_tb
   import fexp_pkg::*;
();

   // ieee single rounding of an exact or double value, nearest even, subnormals kept
   function automatic logic [31:0] round_to_single(input real v);
      logic [63:0] db;
      logic [63:0] mm;
      logic [63:0] keep;
      logic [63:0] rem;
      logic [63:0] half;
      logic [63:0] sum;
      int          fe;
      int          sh;
      logic        up;
      db = $realtobits(v);
      if (db[62:0] == 63'd0) return {db[63], 31'd0};
      fe = int'(db[62:52]) - 1023 + 127;
      if (fe >= 255) return {db[63], PINF_BITS[30:0]};
      mm = {11'd0, 1'b1, db[51:0]};
      sh = (fe >= 1) ? 29 : 29 + (1 - fe);
      if (sh >= 64) begin
         keep = 64'd0;
         up   = 1'b0;
      end else begin
         keep = mm >> sh;
         rem  = mm & ((64'd1 << sh) - 64'd1);
         half = 64'd1 << (sh - 1);
         up   = (rem > half) || (rem == half && keep[0]);
      end
      sum = ((fe >= 1) ? (64'(fe - 1) << 23) : 64'd0) + keep + 64'(up);
      if (sum >= 64'h7F80_0000) return {db[63], PINF_BITS[30:0]};
      return {db[63], sum[30:0]};
   endfunction

   // finite single to real, subnormals included
   function automatic real single_to_real(input logic [31:0] f);
      real mag;
      if (f[30:23] == 8'd0) mag = real'(f[22:0]) * (2.0 ** -149);
      else mag = $bitstoreal({1'b0, 11'(int'(f[30:23]) + 896), f[22:0], 29'd0});
      return f[31] ? -mag : mag;
   endfunction

   class exp_scoreboard;
      logic [32:0] pending_q[$];
      int          mismatches;
      int          checked;
      int          special_hits;

      function logic [31:0] fmul(input logic [31:0] a, input logic [31:0] b);
         return round_to_single(single_to_real(a) * single_to_real(b));
      endfunction

      function logic [31:0] fadd(input logic [31:0] a, input logic [31:0] b);
         return round_to_single(single_to_real(a) + single_to_real(b));
      endfunction

      // expected exp(x) bit pattern
      function logic [31:0] exp_of(input logic [31:0] x);
         real         xr;
         logic [31:0] t;
         logic [31:0] frac;
         logic [31:0] r;
         logic [31:0] r2;
         logic [31:0] r3;
         logic [31:0] r4;
         logic [31:0] r5;
         logic [31:0] r6;
         logic [31:0] p;
         logic [31:0] nf;
         int          n;
         if (x[30:0] > PINF_BITS[30:0]) return QNAN_BITS;
         if (x[30:0] == PINF_BITS[30:0]) return x[31] ? 32'd0 : PINF_BITS;
         xr = single_to_real(x);
         if (xr > 88.0) return PINF_BITS;
         if (xr < -87.0) return 32'd0;
         t    = fmul(x, INV_LN2_BITS);
         n    = $rtoi(single_to_real(t));
         nf   = round_to_single(real'(n));
         frac = fadd(t, {~nf[31], nf[30:0]});
         if (single_to_real(frac) >= 0.5) n++;
         else if (single_to_real(frac) <= -0.5) n--;
         nf = round_to_single(real'(n));
         r  = fmul(nf, LN2_BITS);
         r  = fadd(x, {~r[31], r[30:0]});
         r2 = fmul(r, r);
         r3 = fmul(r2, r);
         r4 = fmul(r2, r2);
         r5 = fmul(r4, r);
         r6 = fmul(r4, r2);
         p  = fadd(ONE_BITS, r);
         p  = fadd(p, fmul(C2_BITS, r2));
         p  = fadd(p, fmul(C3_BITS, r3));
         p  = fadd(p, fmul(C4_BITS, r4));
         p  = fadd(p, fmul(C5_BITS, r5));
         p  = fadd(p, fmul(C6_BITS, r6));
         return fmul(p, {1'b0, 8'(127 + n), 23'd0});
      endfunction

      function void note_input(input logic [31:0] x, input logic last);
         logic [31:0] y;
         y = exp_of(x);
         if (y == QNAN_BITS || y == PINF_BITS || y == 32'd0) special_hits++;
         pending_q.push_back({last, y});
      endfunction

      function void check_result(input logic [31:0] y, input logic last);
         logic [32:0] want;
         checked++;
         if (pending_q.size() == 0) begin
            mismatches++;
            $display("%0t: unexpected beat y=%h last=%b", $time, y, last);
            return;
         end
         want = pending_q.pop_front();
         if (want[31:0] !== y) begin
            mismatches++;
            $display("%0t: y_bits expected %h actual %h", $time, want[31:0], y);
         end
         if (want[32] !== last) begin
            mismatches++;
            $display("%0t: last_out expected %b actual %b", $time, want[32], last);
         end
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [31:0] req_x_bits = 32'd0;
   logic        req_last_in = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [31:0] rsp_y_bits;
   logic        rsp_last_out;

   exp_scoreboard sb = new();
   bit            long_hold_req = 1'b0;  // asks the receiver for one long stall
   bit            zero_gaps = 1'b0;      // sender runs back to back
   int            beats_sent = 0;

   always #6 clock = ~clock;

   float32_exp_approx_unit u_top (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_x_bits   (req_x_bits),
      .req_last_in  (req_last_in),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_y_bits   (rsp_y_bits),
      .rsp_last_out (rsp_last_out)
   );

   // gap drawn per item; some runs of items go with no idling at all
   function automatic int draw_gap();
      if (zero_gaps || $urandom_range(0, 3) == 0) return 0;
      return $urandom_range(0, 9);
   endfunction

   // offer one beat from the falling edge and hold it until taken
   task automatic send_beat(input logic [31:0] x, input logic last);
      int gap;
      gap = draw_gap();
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_x_bits  = x;
      req_last_in = last;
      req_valid   = 1'b1;
      forever begin
         @(posedge clock);
         if (!req_stall) break;
      end
      sb.note_input(x, last);
      beats_sent++;
      @(negedge clock);
   endtask

   // idle the sender until the pipeline has drained
   task automatic drain();
      req_valid = 1'b0;
      while (sb.pending_q.size() != 0) @(negedge clock);
   endtask

   // random x: mostly in range, some raw patterns, some near the clamps
   function automatic logic [31:0] random_x();
      int sel;
      sel = $urandom_range(0, 9);
      if (sel < 6) return round_to_single(real'($urandom_range(0, 180000)) / 1000.0 - 90.0);
      if (sel < 8) return $urandom();
      if (sel == 8) return round_to_single((real'($urandom_range(0, 2000)) / 1000.0 - 1.0) *
                                           (2.0 ** -real'($urandom_range(0, 140))));
      return ($urandom_range(0, 1) ? HI_BITS : {1'b1, LO_MAG_BITS})
             + 32'($urandom_range(0, 8)) - 32'd4;
   endfunction

   // response side: stall decided at each falling edge, beat checked at the rising edge
   initial begin : receiver
      int hold;
      hold = 0;
      forever begin
         @(negedge clock);
         if (long_hold_req) begin
            long_hold_req = 1'b0;
            hold = 300;
         end
         rsp_stall = (hold > 0);
         if (hold > 0) hold--;
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall) begin
            sb.check_result(rsp_y_bits, rsp_last_out);
            if (hold == 0 && $urandom_range(0, 2) != 0) hold = $urandom_range(0, 9);
         end
      end
   end

   // directed corners, then random traffic with pauses and back pressure
   initial begin : stimulus
      logic [31:0] corners[$];
      corners = '{32'h0000_0000, 32'h8000_0000, ONE_BITS, 32'hBF80_0000,
                  HI_BITS, 32'h42B0_0001, {1'b1, LO_MAG_BITS}, {1'b1, LO_MAG_BITS} + 32'd1,
                  PINF_BITS, 32'hFF80_0000, QNAN_BITS, 32'h7F80_0001, 32'hFFFF_FFFF,
                  32'h7F7F_FFFF, 32'hFF7F_FFFF, 32'h0000_0001, 32'h8000_0001,
                  32'h3EB1_7218, 32'hBEB1_7218, 32'h3F85_1592, 32'h42AF_FFFF,
                  32'hC2AD_FFFF, 32'h3400_0000, 32'h42B0_0000 - 32'd2};
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      foreach (corners[i]) send_beat(corners[i], i[0]);

      // sender waits here for every outstanding beat
      drain();

      for (int i = 0; i < 2000; i++) begin
         if (i == 600) begin
            // receiver holds off while the sender keeps pushing, so req_stall must rise
            long_hold_req = 1'b1;
            zero_gaps = 1'b1;
         end
         if (i == 700) zero_gaps = 1'b0;
         if (i == 1400) drain();
         send_beat(random_x(), 1'($urandom_range(0, 1)));
      end
      drain();
      repeat (30) @(negedge clock);

      $display("run covered %0d beats sent, %0d results checked, %0d clamp or nan results",
               beats_sent, sb.checked, sb.special_hits);
      $display("directed corners: zeros, infinities, nans, clamp edges, subnormals, halves");
      if (sb.mismatches == 0 && sb.pending_q.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

   // watchdog
   initial begin : watchdog
      #5ms;
      $display("FAILURE");
      $finish;
   end

endmodule

`default_nettype wire
